// File: hw/rtl/spbp_pkg.sv
`default_nettype none

package spbp_pkg;

    localparam int SPEED_BITS    = 9;
    localparam int PULSE_BITS    = 16;
    localparam int SHIFT_BITS    = 4;
    localparam int STEP_BITS     = 8;
    localparam int MASK_BITS     = 8;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_PULSE_OFFSET = 3'd0,
        REG_PULSE_SHIFT  = 3'd1,
        REG_DEAD_BAND    = 3'd2,
        REG_CENTER_SPEED = 3'd3,
        REG_FULL_SCALE   = 3'd4,
        REG_PHASE_STEP   = 3'd5,
        REG_RAMP_MASK    = 3'd6
    } reg_idx_t;

    typedef enum logic {
        KIND_TICK  = 1'b0,
        KIND_PULSE = 1'b1
    } item_kind_t;

    typedef struct packed {
        logic [PULSE_BITS-1:0] pulse_offset;
        logic [SHIFT_BITS-1:0] pulse_shift;
        logic [SPEED_BITS-1:0] dead_band;
        logic [SPEED_BITS-1:0] center_speed;
        logic [SPEED_BITS-1:0] full_scale;
        logic [STEP_BITS-1:0]  phase_step;
        logic [MASK_BITS-1:0]  ramp_mask;
    } cfg_t;

    // classified word handed from front to back
    typedef struct packed {
        item_kind_t            kind;
        logic [SPEED_BITS-1:0] target;
        logic                  link_hit;
    } entry_t;

    typedef struct packed {
        logic                  abs_pwm;
        logic                  dir_a;
        logic                  dir_b;
        logic                  idle_pin;
        logic                  linked;
        logic [SPEED_BITS-1:0] speed;
    } result_t;

    localparam logic [PULSE_BITS-1:0] RST_PULSE_OFFSET = 16'd760;
    localparam logic [SHIFT_BITS-1:0] RST_PULSE_SHIFT  = 4'd4;
    localparam logic [SPEED_BITS-1:0] RST_DEAD_BAND    = SPEED_BITS'(33);
    localparam logic [SPEED_BITS-1:0] RST_CENTER_SPEED = SPEED_BITS'(250);
    localparam logic [SPEED_BITS-1:0] RST_FULL_SCALE   = SPEED_BITS'(500);
    localparam logic [STEP_BITS-1:0]  RST_PHASE_STEP   = 8'd4;
    localparam logic [MASK_BITS-1:0]  RST_RAMP_MASK    = 8'd7;

endpackage

`default_nettype wire

// File: hw/rtl/spbp_ifs.sv
`default_nettype none

interface spbp_in_if;
    logic                              valid;
    logic                              ready;
    logic                              cmd;
    logic [spbp_pkg::PULSE_BITS-1:0]   pulse_width;

    modport source (output valid, output cmd, output pulse_width, input ready);
    modport sink   (input valid, input cmd, input pulse_width, output ready);
endinterface

interface spbp_out_if;
    logic                              valid;
    logic                              ready;
    logic                              abs_pwm;
    logic                              dir_a;
    logic                              dir_b;
    logic                              idle_pin;
    logic                              linked;
    logic [spbp_pkg::SPEED_BITS-1:0]   speed;

    modport source (output valid, output abs_pwm, output dir_a, output dir_b,
                    output idle_pin, output linked, output speed, input ready);
    modport sink   (input valid, input abs_pwm, input dir_a, input dir_b,
                    input idle_pin, input linked, input speed, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/spbp_front.sv
`default_nettype none

module spbp_front (
    spbp_in_if.sink                 item,
    input  spbp_pkg::cfg_t          cfg,
    input  logic                    q_ready,
    output logic                    q_push,
    output spbp_pkg::entry_t        q_data
);

    logic [spbp_pkg::PULSE_BITS-1:0]  diff;
    logic signed [spbp_pkg::PULSE_BITS-1:0] val;
    logic signed [spbp_pkg::PULSE_BITS:0]   val_x;
    logic signed [spbp_pkg::PULSE_BITS:0]   db_x;
    logic signed [spbp_pkg::PULSE_BITS:0]   fs_x;

    assign item.ready = q_ready;
    assign q_push     = item.valid && q_ready;

    // 16-bit wrap, arithmetic shift
    assign diff  = item.pulse_width - cfg.pulse_offset;
    assign val   = $signed(diff) >>> cfg.pulse_shift;
    assign val_x = {val[spbp_pkg::PULSE_BITS-1], val};
    assign db_x  = $signed((spbp_pkg::PULSE_BITS+1)'(cfg.dead_band));
    assign fs_x  = $signed((spbp_pkg::PULSE_BITS+1)'(cfg.full_scale));

    always_comb
    begin
        q_data.kind     = item.cmd ? spbp_pkg::KIND_PULSE : spbp_pkg::KIND_TICK;
        q_data.link_hit = (val_x > db_x) && (val_x < fs_x);
        if (val_x < 0)
        begin
            q_data.target = '0;
        end
        else if (val_x > fs_x)
        begin
            q_data.target = cfg.full_scale;
        end
        else
        begin
            q_data.target = val[spbp_pkg::SPEED_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/spbp_queue.sv
`default_nettype none

module spbp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  spbp_pkg::entry_t    push_data,
    output logic                push_ready,
    input  logic                pop,
    output logic                pop_valid,
    output spbp_pkg::entry_t    pop_data
);

    spbp_pkg::entry_t mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/spbp_back.sv
`default_nettype none

module spbp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  spbp_pkg::cfg_t      cfg,
    input  logic                q_valid,
    input  spbp_pkg::entry_t    q_data,
    output logic                q_pop,
    spbp_out_if.source          result
);

    localparam int SB = spbp_pkg::SPEED_BITS;

    logic [SB-1:0] cur_reg,    cur_next;
    logic [SB-1:0] target_reg, target_next;
    logic [SB-1:0] phase_reg,  phase_next;
    logic          link_reg,   link_next;
    logic          abs_reg,    abs_next;
    logic          rev_reg,    rev_next;
    logic          fwd_reg,    fwd_next;
    logic          idle_reg,   idle_next;
    logic          ovalid_reg;
    spbp_pkg::result_t res_reg;

    logic [SB-1:0] spd;
    logic [SB-1:0] spd_dev;
    logic [SB:0]   sr;
    logic [SB:0]   abs_lim;
    logic [SB+1:0] idle_lim;
    logic [SB:0]   phase_sum;

    assign q_pop = q_valid && (!ovalid_reg || result.ready);

    // tick datapath
    always_comb
    begin
        spd = cur_reg;
        if ((cur_reg != target_reg) &&
            ((phase_reg[spbp_pkg::MASK_BITS-1:0] & cfg.ramp_mask) == '0))
        begin
            spd = (target_reg > cur_reg) ? cur_reg + 1'b1 : cur_reg - 1'b1;
        end
        spd_dev   = (spd >= cfg.center_speed) ? spd - cfg.center_speed
                                              : cfg.center_speed - spd;
        sr        = {spd_dev, 1'b0};
        abs_lim   = {1'b0, spd} + {1'b0, cfg.dead_band};
        idle_lim  = {1'b0, sr} + (SB+2)'(cfg.dead_band);
        phase_sum = {1'b0, phase_reg} + (SB+1)'(cfg.phase_step);
    end

    always_comb
    begin
        cur_next    = cur_reg;
        target_next = target_reg;
        phase_next  = phase_reg;
        link_next   = link_reg;
        abs_next    = abs_reg;
        rev_next    = rev_reg;
        fwd_next    = fwd_reg;
        idle_next   = idle_reg;
        if (q_pop)
        begin
            if (q_data.kind == spbp_pkg::KIND_PULSE)
            begin
                target_next = q_data.target;
                if (q_data.link_hit)
                begin
                    link_next = 1'b1;
                end
            end
            else if (link_reg)
            begin
                cur_next = spd;
                if (phase_reg == '0)
                begin
                    if (sr > (SB+1)'(cfg.dead_band))
                    begin
                        idle_next = 1'b0;
                        fwd_next  = (spd >= cfg.center_speed);
                        rev_next  = (spd <  cfg.center_speed);
                    end
                    if (spd > cfg.dead_band)
                    begin
                        idle_next = 1'b0;
                        abs_next  = 1'b1;
                    end
                end
                if ((SB+1)'(phase_reg) >= abs_lim)
                begin
                    abs_next = 1'b0;
                end
                if ((SB+2)'(phase_reg) >= idle_lim)
                begin
                    idle_next = 1'b1;
                    rev_next  = 1'b0;
                    fwd_next  = 1'b0;
                end
                if (phase_sum >= (SB+1)'(cfg.full_scale))
                begin
                    phase_next = '0;
                end
                else
                begin
                    phase_next = phase_sum[SB-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg    <= '0;
            target_reg <= '0;
            phase_reg  <= '0;
            link_reg   <= 1'b0;
            abs_reg    <= 1'b0;
            rev_reg    <= 1'b0;
            fwd_reg    <= 1'b0;
            idle_reg   <= 1'b1;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            cur_reg    <= cur_next;
            target_reg <= target_next;
            phase_reg  <= phase_next;
            link_reg   <= link_next;
            abs_reg    <= abs_next;
            rev_reg    <= rev_next;
            fwd_reg    <= fwd_next;
            idle_reg   <= idle_next;
            if (q_pop)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // output word, state after the item
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            res_reg.abs_pwm  <= abs_next;
            res_reg.dir_a    <= rev_next;
            res_reg.dir_b    <= fwd_next;
            res_reg.idle_pin <= idle_next;
            res_reg.linked   <= link_next;
            res_reg.speed    <= cur_next;
        end
    end

    assign result.valid    = ovalid_reg;
    assign result.abs_pwm  = res_reg.abs_pwm;
    assign result.dir_a    = res_reg.dir_a;
    assign result.dir_b    = res_reg.dir_b;
    assign result.idle_pin = res_reg.idle_pin;
    assign result.linked   = res_reg.linked;
    assign result.speed    = res_reg.speed;

endmodule

`default_nettype wire

// File: hw/rtl/servo_pulse_to_bidir_pwm.sv
// Channel   Dir  Handshake     Payload
// item      in   valid/ready   cmd, pulse_width
// result    out  valid/ready   abs_pwm, dir_a, dir_b, idle_pin, linked, speed
// cfg       in   cfg_we        cfg_index, cfg_wdata
//
// One word per cycle sustained while result is ready; every word taken yields
// one result word (front decode into a 2-entry queue, back state update into
// the output register). The back end retires one queue entry per cycle unless stalled.
// Reset loads register defaults, clears speed/phase/link, drives idle high.
// A stalled result holds the back end; the queue holds up to two words.
`default_nettype none

module servo_pulse_to_bidir_pwm (
    input  logic                                   clk,
    input  logic                                   rst_n,
    spbp_in_if.sink                                item,
    spbp_out_if.source                             result,
    input  logic                                   cfg_we,
    input  logic [spbp_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [spbp_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);

    spbp_pkg::cfg_t   cfg_reg;
    logic             q_push;
    logic             q_ready;
    logic             q_pop;
    logic             q_valid;
    spbp_pkg::entry_t q_in;
    spbp_pkg::entry_t q_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_offset <= spbp_pkg::RST_PULSE_OFFSET;
            cfg_reg.pulse_shift  <= spbp_pkg::RST_PULSE_SHIFT;
            cfg_reg.dead_band    <= spbp_pkg::RST_DEAD_BAND;
            cfg_reg.center_speed <= spbp_pkg::RST_CENTER_SPEED;
            cfg_reg.full_scale   <= spbp_pkg::RST_FULL_SCALE;
            cfg_reg.phase_step   <= spbp_pkg::RST_PHASE_STEP;
            cfg_reg.ramp_mask    <= spbp_pkg::RST_RAMP_MASK;
        end
        else if (cfg_we)
        begin
            case (spbp_pkg::reg_idx_t'(cfg_index))
                spbp_pkg::REG_PULSE_OFFSET:
                    cfg_reg.pulse_offset <= cfg_wdata[spbp_pkg::PULSE_BITS-1:0];
                spbp_pkg::REG_PULSE_SHIFT:
                    cfg_reg.pulse_shift  <= cfg_wdata[spbp_pkg::SHIFT_BITS-1:0];
                spbp_pkg::REG_DEAD_BAND:
                    cfg_reg.dead_band    <= cfg_wdata[spbp_pkg::SPEED_BITS-1:0];
                spbp_pkg::REG_CENTER_SPEED:
                    cfg_reg.center_speed <= cfg_wdata[spbp_pkg::SPEED_BITS-1:0];
                spbp_pkg::REG_FULL_SCALE:
                    cfg_reg.full_scale   <= cfg_wdata[spbp_pkg::SPEED_BITS-1:0];
                spbp_pkg::REG_PHASE_STEP:
                    cfg_reg.phase_step   <= cfg_wdata[spbp_pkg::STEP_BITS-1:0];
                spbp_pkg::REG_RAMP_MASK:
                    cfg_reg.ramp_mask    <= cfg_wdata[spbp_pkg::MASK_BITS-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    spbp_front u_front (
        .item    (item),
        .cfg     (cfg_reg),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_data  (q_in)
    );

    spbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_data   (q_out)
    );

    spbp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

`default_nettype wire

// File: hw/rtl/spbp_checker.sv
`default_nettype none

module spbp_checker (
    input  logic        clk,
    input  logic        rst_n,
    spbp_out_if.source  result
);

    logic seen_link_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_link_reg <= 1'b0;
        end
        else if (result.valid && result.ready && result.linked)
        begin
            seen_link_reg <= 1'b1;
        end
    end

    // stalled word stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid)
        else $error("result word dropped while stalled");

    // link never drops once reported
    a_link: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && seen_link_reg |-> result.linked)
        else $error("link flag cleared");

    a_dirs: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.dir_a && result.dir_b))
        else $error("both direction outputs high");

    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.dir_a || result.dir_b) |-> !result.idle_pin)
        else $error("idle high while driving a direction");

    a_nolink: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.linked |-> (result.speed == '0))
        else $error("speed moved before link");

endmodule

bind servo_pulse_to_bidir_pwm spbp_checker u_spbp_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .result (result)
);

`default_nettype wire
